[hdl/lcg48_bounded_random_unit_defines.svh]
// Assertion macros shared by the checker of the bounded random unit.
// Depends on nothing; the file that includes it supplies clk and rst.
`ifndef LCG48_BOUNDED_RANDOM_UNIT_DEFINES_SVH
`define LCG48_BOUNDED_RANDOM_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lbr_pkg.sv]
// Shared widths, opcodes and generator constants of the bounded random unit.
// Depends on nothing; every module imports it.
package lbr_pkg;

  localparam int StateW   = 48;
  localparam int ValueW   = 32;
  localparam int DrawW    = 31;
  localparam int CountW   = 6;
  localparam int BoundW   = 32;
  localparam int OpW      = 2;
  localparam int InDataW  = 88;
  localparam int OutDataW = 80;

  // The 35-bit multiplier is applied in two halves split at bit MulSplit.
  localparam int MulSplit = 17;
  localparam int MulOpW   = 18;

  localparam logic [StateW-1:0] LcgMult = 48'h0005_DEEC_E66D;
  localparam logic [StateW-1:0] LcgInc  = 48'h0000_0000_000B;
  localparam logic [MulOpW-1:0] MultLo  = {1'b0, LcgMult[16:0]};
  localparam logic [MulOpW-1:0] MultHi  = LcgMult[34:17];

  typedef enum logic [OpW-1:0] {
    OP_RESEED    = 2'd0,
    OP_NEXT_BITS = 2'd1,
    OP_NEXT_INT  = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

endpackage

[hdl/lbr_mul.sv]
// Shared constant multiplier of the generator: state times one half of the
// LCG multiplier, modulo 2^48. Depends on lbr_pkg.
module lbr_mul import lbr_pkg::*; (
  input  logic [StateW-1:0] a,
  input  logic              hi_half,
  output logic [StateW-1:0] prod
);

  logic [MulOpW-1:0]        b;
  logic [StateW+MulOpW-1:0] full;

  assign b    = hi_half ? MultHi : MultLo;
  assign full = {{MulOpW{1'b0}}, a} * {{StateW{1'b0}}, b};
  assign prod = full[StateW-1:0];

endmodule

[hdl/lcg48_bounded_random_unit.sv]
// Accept to output valid: reseed and unused op go straight to the finish state; next
// bits and power-of-two bounded draws pass both multiply states and evaluate; other
// bounded draws also run the 31-step restoring remainder loop and the overflow check,
// and a rejected draw returns to the multiply states. One word at a time; the unit is
// ready again once its result is registered. Reset (rst, synchronous, active high)
// clears the generator state and the output valid. Depends on lbr_pkg and lbr_mul.
module lcg48_bounded_random_unit import lbr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // s_tdata, low bit up: seed_value[47:0], bit_count[53:48], bound[85:54], zero pad.
  input  logic [InDataW-1:0]  s_tdata,
  // s_tuser: op[1:0].
  input  logic [OpW-1:0]      s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // m_tdata, low bit up: value[31:0], state_now[79:32].
  output logic [OutDataW-1:0] m_tdata
);

  // One-hot sequencer. A draw goes through two multiply states that advance the
  // state, an evaluate state that looks at the new state, and for bounds that are not a
  // power of two a bit-serial remainder followed by the overflow rejection test.
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL_LO = 7'b0000010,
    ST_MUL_HI = 7'b0000100,
    ST_EVAL   = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_CHECK  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  // Clamp the requested bit count into 1..32.
  function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] c);
    logic [CountW-1:0] r;
    r = c;
    if (c == '0) begin
      r = CountW'(1);
    end else if (c > CountW'(ValueW)) begin
      r = CountW'(ValueW);
    end
    return r;
  endfunction

  // A bound with at most one set bit scales the 31-bit draw: bound * d >> 31
  // is just d shifted right by 31 minus the position of that bit.
  function automatic logic [ValueW-1:0] pow2_scale(input logic [DrawW-1:0] d,
                                                   input logic [BoundW-1:0] b);
    logic [ValueW-1:0] r;
    r = '0;
    for (int i = 0; i < BoundW; i++) begin
      if (b[i]) begin
        r = r | ({1'b0, d} >> (DrawW - i));
      end
    end
    return r;
  endfunction

  state_t              st;
  op_t                 op_r;
  logic [CountW-1:0]   count_r;
  logic [BoundW-1:0]   bound_r;
  logic [StateW-1:0]   lcg_state;
  logic [StateW-1:0]   acc;
  logic [DrawW-1:0]    draw;
  logic [BoundW-1:0]   rem;
  logic [4:0]          bit_idx;
  logic [ValueW-1:0]   result;

  logic [StateW-1:0]   prod;
  logic [StateW-1:0]   state_adv;
  logic [ValueW-1:0]   top_bits;
  logic                bound_pow2;
  logic [BoundW:0]     rem_shift;
  logic [BoundW:0]     rem_sub;
  logic [ValueW-1:0]   reject_sum;
  logic                accept_draw;
  logic                out_free;

  // The shared multiplier takes the low constant half first, the high half next.
  lbr_mul u_mul (
    .a       (lcg_state),
    .hi_half (st == ST_MUL_HI),
    .prod    (prod)
  );

  // Second multiply cycle: low-half product plus the high-half product moved up
  // by the split point, plus the increment, all modulo 2^48.
  assign state_adv = acc + {prod[StateW-MulSplit-1:0], {MulSplit{1'b0}}} + LcgInc;

  assign top_bits   = lcg_state[StateW-1:StateW-ValueW] >> (CountW'(ValueW) - count_r);
  assign bound_pow2 = (bound_r & (bound_r - BoundW'(1))) == '0;

  // One restoring remainder step per cycle, draw bits taken from the top down.
  assign rem_shift = {rem, draw[bit_idx]};
  assign rem_sub   = rem_shift - {1'b0, bound_r};

  // Rejection test of the signed 32-bit form: d - v + bound - 1 must stay
  // non-negative. Bounds above 2^31 never reject.
  assign reject_sum  = {1'b0, draw} - rem + bound_r - ValueW'(1);
  assign accept_draw = (bound_r > 32'h8000_0000) || !reject_sum[ValueW-1];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (st == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      lcg_state <= '0;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
      op_r      <= OP_NONE;
      count_r   <= '0;
      bound_r   <= '0;
      acc       <= '0;
      draw      <= '0;
      rem       <= '0;
      bit_idx   <= '0;
      result    <= '0;
    end else begin
      // In the finish cycle the outgoing word is replaced there directly.
      if (m_tvalid && m_tready && st != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (s_tvalid) begin
            op_r    <= op_t'(s_tuser);
            count_r <= clamp_count(s_tdata[53:48]);
            bound_r <= s_tdata[85:54];
            result  <= '0;
            case (op_t'(s_tuser))
              OP_RESEED: begin
                lcg_state <= s_tdata[StateW-1:0] ^ LcgMult;
                st        <= ST_FINISH;
              end
              OP_NEXT_BITS, OP_NEXT_INT: begin
                st <= ST_MUL_LO;
              end
              default: begin
                st <= ST_FINISH;
              end
            endcase
          end
        end
        ST_MUL_LO: begin
          acc <= prod;
          st  <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          lcg_state <= state_adv;
          st        <= ST_EVAL;
        end
        ST_EVAL: begin
          draw <= lcg_state[StateW-1:StateW-DrawW];
          if (op_r == OP_NEXT_BITS) begin
            result <= top_bits;
            st     <= ST_FINISH;
          end else if (bound_pow2) begin
            result <= pow2_scale(lcg_state[StateW-1:StateW-DrawW], bound_r);
            st     <= ST_FINISH;
          end else begin
            rem     <= '0;
            bit_idx <= 5'(DrawW - 1);
            st      <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!rem_sub[BoundW]) begin
            rem <= rem_sub[BoundW-1:0];
          end else begin
            rem <= rem_shift[BoundW-1:0];
          end
          bit_idx <= bit_idx - 5'd1;
          if (bit_idx == '0) begin
            st <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (accept_draw) begin
            result <= rem;
            st     <= ST_FINISH;
          end else begin
            st <= ST_MUL_LO;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {lcg_state, result};
            st       <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/lbr_checker.sv]
// Port-level checker of the bounded random unit, bound to its top level.
// Depends on lbr_pkg and lcg48_bounded_random_unit_defines.svh.
`include "lcg48_bounded_random_unit_defines.svh"

module lbr_checker import lbr_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  // A stalled output word stays put.
  `LBR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

  // Once a word is taken in, the unit is busy with it.
  `LBR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "unit ready right after accepting a word")

  // A fresh output word only comes out of a busy period.
  `LBR_ASSERT_NOW(a_out_from_busy, $rose(m_tvalid), $past(!s_tready), "output word without prior work")

endmodule

bind lcg48_bounded_random_unit lbr_checker u_lbr_checker (.*);
